// File: rtl/directed_graph_edge_store_assert.svh
// Assertion macros shared by the edge store RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef DIRECTED_GRAPH_EDGE_STORE_ASSERT_SVH
`define DIRECTED_GRAPH_EDGE_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define DGES_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds.
`define DGES_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `DGES_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define DGES_ASSERT(label, clk, rst_n, prop, msg)
`define DGES_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/dges_pkg.sv
// Shared types and constants of the directed-graph edge store.
// No dependencies; used by every module of the block.
package dges_pkg;

    localparam int KIND_W   = 3;
    localparam int VTX_W    = 4;
    localparam int ROW_W    = 16;
    localparam int VCOUNT_W = 5;
    localparam int IDX_LIMIT = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HAS      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OUT_LIST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IN_LIST  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ROW      = 3'd5;

    // Register index is paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd10;

    typedef struct packed {
        logic             ok;
        logic [VTX_W-1:0] listed_vertex;
        logic             none;
        logic [ROW_W-1:0] row_bits;
        logic             last;
    } result_t;

    typedef struct packed {
        logic hit;       // entry equals the search key
        logic in_range;  // entry below the active vertex count
        logic at_end;    // position has reached the list length
        logic is_final;  // position is the last entry of the list
    } cmp_flags_t;

endpackage

// File: rtl/directed_graph_edge_store.sv
// Top level of the directed-graph edge store: register port and result register.
// Depends on dges_pkg, dges_edge_mem, dges_ctrl and the assertion macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid, req_stall | kind, source_vertex, target_vertex
//  rsp     | rsp_valid, rsp_stall | ok, listed_vertex, none, row_bits, last
//  cfg     | psel, penable, ...   | vertex_count at paddr 0
//
// One request is in flight at a time; req_stall stays high until its last beat
// has entered the result register. Each list entry takes an address step, then
// a compare on the registered read data. Remove also moves every later entry
// down by one, out-list gives one beat per entry and in-list walks every list
// below vertex_count. Reset clears the list lengths and sets vertex_count to 10;
// a stalled beat holds.
`include "directed_graph_edge_store_assert.svh"

module directed_graph_edge_store #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [dges_pkg::KIND_W-1:0]   kind,
    input  logic [dges_pkg::VTX_W-1:0]    source_vertex,
    input  logic [dges_pkg::VTX_W-1:0]    target_vertex,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          ok,
    output logic [dges_pkg::VTX_W-1:0]    listed_vertex,
    output logic                          none,
    output logic [dges_pkg::ROW_W-1:0]    row_bits,
    output logic                          last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dges_pkg::ADDR_W-1:0]   paddr,
    input  logic [dges_pkg::DATA_W-1:0]   pwdata,
    output logic [dges_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;

    logic [dges_pkg::VCOUNT_W-1:0] vcount_reg;
    logic                          cfg_write;

    logic                          busy;
    logic                          req_accept;
    logic                          res_ready;
    logic                          res_push;
    dges_pkg::result_t             res;
    dges_pkg::result_t             out_reg;
    logic                          rsp_valid_reg;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [dges_pkg::VTX_W-1:0]    rd_data;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [dges_pkg::VTX_W-1:0]    wr_data;

    // Register port: zero wait states, vertex_count is the only register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == dges_pkg::REG_VERTEX_COUNT);
    assign prdata    = (paddr[2] == dges_pkg::REG_VERTEX_COUNT)
                       ? {{(dges_pkg::DATA_W - dges_pkg::VCOUNT_W){1'b0}}, vcount_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= dges_pkg::VCOUNT_RESET;
        end
        else if (cfg_write)
        begin
            vcount_reg <= pwdata[dges_pkg::VCOUNT_W-1:0];
        end
    end

    // Request side: take a new beat only while the sequencer is idle
    assign req_stall  = busy;
    assign req_accept = req_valid && !req_stall;

    dges_edge_mem #(
        .AW(AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dges_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .LW           (LW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_accept    (req_accept),
        .kind          (kind),
        .source_vertex (source_vertex),
        .target_vertex (target_vertex),
        .vertex_count  (vcount_reg),
        .busy          (busy),
        .res_ready     (res_ready),
        .res_push      (res_push),
        .res           (res),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // Result register: load when empty or when the held beat leaves this cycle
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign ok            = out_reg.ok;
    assign listed_vertex = out_reg.listed_vertex;
    assign none          = out_reg.none;
    assign row_bits      = out_reg.row_bits;
    assign last          = out_reg.last;

    `DGES_ASSERT(a_busy_after_accept, clk, rst_n, req_accept |=> req_stall,
        "request accepted but block not busy")
    `DGES_ASSERT_NEVER(a_push_into_full, clk, rst_n, res_push && rsp_valid_reg && rsp_stall,
        "result pushed over a stalled beat")
    `DGES_ASSERT_NEVER(a_push_when_idle, clk, rst_n, res_push && !busy,
        "result pushed with no request in flight")

endmodule

// File: rtl/dges_edge_mem.sv
// Edge list memory: one write port, one registered read port.
// Depends on dges_pkg for the entry width.
module dges_edge_mem #(
    parameter int AW = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [dges_pkg::VTX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [dges_pkg::VTX_W-1:0] rd_data
);

    logic [dges_pkg::VTX_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/dges_cmp.sv
// Shared compare and step unit: entry match, range test and position advance.
// Depends on dges_pkg for widths and the flag struct.
module dges_cmp #(
    parameter int LW = 5
) (
    input  logic [dges_pkg::VTX_W-1:0]    entry,
    input  logic [dges_pkg::VTX_W-1:0]    key,
    input  logic [dges_pkg::VCOUNT_W-1:0] n_active,
    input  logic [LW-1:0]                 pos,
    input  logic [LW-1:0]                 len,
    output dges_pkg::cmp_flags_t          flags,
    output logic [LW-1:0]                 pos_inc
);

    assign pos_inc        = pos + LW'(1);
    assign flags.hit      = (entry == key);
    assign flags.in_range = ({1'b0, entry} < n_active);
    assign flags.at_end   = (pos == len);
    assign flags.is_final = (pos_inc == len);

endmodule

// File: rtl/dges_ctrl.sv
// Request sequencer: walks edge lists through the shared compare unit.
// Depends on dges_pkg, dges_cmp and the assertion macro header.
`include "directed_graph_edge_store_assert.svh"

module dges_ctrl #(
    parameter int MAX_VERTICES = 16,
    parameter int VW = 4,
    parameter int LW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_accept,
    input  logic [dges_pkg::KIND_W-1:0]   kind,
    input  logic [dges_pkg::VTX_W-1:0]    source_vertex,
    input  logic [dges_pkg::VTX_W-1:0]    target_vertex,
    input  logic [dges_pkg::VCOUNT_W-1:0] vertex_count,
    output logic                          busy,
    input  logic                          res_ready,
    output logic                          res_push,
    output dges_pkg::result_t             res,
    output logic                          rd_en,
    output logic [2*VW-1:0]               rd_addr,
    input  logic [dges_pkg::VTX_W-1:0]    rd_data,
    output logic                          wr_en,
    output logic [2*VW-1:0]               wr_addr,
    output logic [dges_pkg::VTX_W-1:0]    wr_data
);

    localparam int N_CAP = (MAX_VERTICES < dges_pkg::IDX_LIMIT) ? MAX_VERTICES
                                                                 : dges_pkg::IDX_LIMIT;
    localparam int CW = (VW + 1 > dges_pkg::VCOUNT_W) ? VW + 1 : dges_pkg::VCOUNT_W;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DISPATCH  = 8'b0000_0010,
        S_SCAN_RD   = 8'b0000_0100,
        S_SCAN_CMP  = 8'b0000_1000,
        S_SHIFT_RD  = 8'b0001_0000,
        S_SHIFT_WR  = 8'b0010_0000,
        S_NEXT_LIST = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [dges_pkg::KIND_W-1:0] kind_reg;
    logic [dges_pkg::VTX_W-1:0]  src_reg;
    logic [dges_pkg::VTX_W-1:0]  tgt_reg;
    logic [VW-1:0]               list_reg, list_next;
    logic [LW-1:0]               pos_reg, pos_next;
    logic [dges_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [dges_pkg::VTX_W-1:0]  pend_vtx_reg, pend_vtx_next;
    dges_pkg::result_t           res_reg, res_next;

    logic [LW-1:0] len_reg [MAX_VERTICES];
    logic          len_wr_en;
    logic [LW-1:0] len_wr_val;

    logic [dges_pkg::VCOUNT_W-1:0] n_active;
    logic                          src_ok;
    logic                          tgt_ok;
    logic [VW-1:0]                 src_list;
    logic [LW-1:0]                 cur_len;
    logic [CW-1:0]                 list_inc;
    logic                          more_lists;
    logic [dges_pkg::VTX_W-1:0]    key;
    dges_pkg::cmp_flags_t          flags;
    logic [LW-1:0]                 pos_inc;

    function automatic dges_pkg::result_t mk_res(
        input logic                       ok,
        input logic [dges_pkg::VTX_W-1:0] vtx,
        input logic                       none,
        input logic [dges_pkg::ROW_W-1:0] row,
        input logic                       last
    );
        dges_pkg::result_t r;
        r.ok            = ok;
        r.listed_vertex = vtx;
        r.none          = none;
        r.row_bits      = row;
        r.last          = last;
        return r;
    endfunction

    assign n_active = (vertex_count > dges_pkg::VCOUNT_W'(N_CAP))
                      ? dges_pkg::VCOUNT_W'(N_CAP) : vertex_count;
    assign src_ok     = ({1'b0, src_reg} < n_active);
    assign tgt_ok     = ({1'b0, tgt_reg} < n_active);
    assign src_list   = VW'(src_reg);
    assign cur_len    = len_reg[list_reg];
    assign list_inc   = CW'(list_reg) + CW'(1);
    assign more_lists = (list_inc < CW'(n_active));
    assign key        = (kind_reg == dges_pkg::KIND_IN_LIST) ? src_reg : tgt_reg;

    dges_cmp #(
        .LW(LW)
    ) u_cmp (
        .entry    (rd_data),
        .key      (key),
        .n_active (n_active),
        .pos      (pos_reg),
        .len      (cur_len),
        .flags    (flags),
        .pos_inc  (pos_inc)
    );

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        list_next       = list_reg;
        pos_next        = pos_reg;
        row_next        = row_reg;
        pend_valid_next = pend_valid_reg;
        pend_vtx_next   = pend_vtx_reg;
        res_next        = res_reg;
        len_wr_en       = 1'b0;
        len_wr_val      = cur_len;
        rd_en           = 1'b0;
        rd_addr         = {list_reg, pos_reg[VW-1:0]};
        wr_en           = 1'b0;
        wr_addr         = {list_reg, pos_reg[VW-1:0]};
        wr_data         = tgt_reg;
        res_push        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                // Default answer: a single flagged-none beat
                res_next        = mk_res(1'b0, '0, 1'b1, '0, 1'b1);
                ret_next        = S_IDLE;
                state_next      = S_EMIT;
                pos_next        = '0;
                row_next        = '0;
                pend_valid_next = 1'b0;
                unique case (kind_reg)
                    dges_pkg::KIND_ADD, dges_pkg::KIND_REMOVE, dges_pkg::KIND_HAS:
                    begin
                        if (src_ok && tgt_ok)
                        begin
                            list_next  = src_list;
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            res_next = mk_res(1'b0, '0, 1'b0, '0, 1'b1);
                        end
                    end
                    dges_pkg::KIND_OUT_LIST:
                    begin
                        if (src_ok && (len_reg[src_list] != '0))
                        begin
                            list_next  = src_list;
                            state_next = S_SCAN_RD;
                        end
                    end
                    dges_pkg::KIND_IN_LIST:
                    begin
                        if (src_ok)
                        begin
                            list_next  = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    dges_pkg::KIND_ROW:
                    begin
                        if (src_ok)
                        begin
                            list_next  = src_list;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                if (flags.at_end)
                begin
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                    unique case (kind_reg)
                        dges_pkg::KIND_ADD:
                        begin
                            if (cur_len < LW'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = {list_reg, cur_len[VW-1:0]};
                                len_wr_en  = 1'b1;
                                len_wr_val = cur_len + LW'(1);
                                res_next   = mk_res(1'b1, '0, 1'b0, '0, 1'b1);
                            end
                            else
                            begin
                                res_next = mk_res(1'b0, '0, 1'b0, '0, 1'b1);
                            end
                        end
                        dges_pkg::KIND_REMOVE, dges_pkg::KIND_HAS:
                        begin
                            res_next = mk_res(1'b0, '0, 1'b0, '0, 1'b1);
                        end
                        dges_pkg::KIND_ROW:
                        begin
                            res_next = mk_res(1'b1, '0, 1'b0, row_reg, 1'b1);
                        end
                        dges_pkg::KIND_IN_LIST:
                        begin
                            state_next = S_NEXT_LIST;
                        end
                        default:
                        begin
                            // Out-list: last beat already went out
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                pos_next   = pos_inc;
                state_next = S_SCAN_RD;
                unique case (kind_reg)
                    dges_pkg::KIND_ADD:
                    begin
                        if (flags.hit)
                        begin
                            res_next   = mk_res(1'b0, '0, 1'b0, '0, 1'b1);
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                    end
                    dges_pkg::KIND_HAS:
                    begin
                        if (flags.hit)
                        begin
                            res_next   = mk_res(1'b1, '0, 1'b0, '0, 1'b1);
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                    end
                    dges_pkg::KIND_REMOVE:
                    begin
                        if (flags.hit)
                        begin
                            // Hold the position of the match and close the gap
                            pos_next   = pos_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    dges_pkg::KIND_OUT_LIST:
                    begin
                        res_next   = mk_res(1'b0, rd_data, 1'b0, '0, flags.is_final);
                        ret_next   = S_SCAN_RD;
                        state_next = S_EMIT;
                    end
                    dges_pkg::KIND_ROW:
                    begin
                        if (flags.in_range)
                        begin
                            row_next = row_reg | (dges_pkg::ROW_W'(1) << rd_data);
                        end
                    end
                    dges_pkg::KIND_IN_LIST:
                    begin
                        if (flags.hit)
                        begin
                            pend_valid_next = 1'b1;
                            pend_vtx_next   = dges_pkg::VTX_W'(list_reg);
                            state_next      = S_NEXT_LIST;
                            if (pend_valid_reg)
                            begin
                                res_next   = mk_res(1'b0, pend_vtx_reg, 1'b0, '0, 1'b0);
                                ret_next   = S_NEXT_LIST;
                                state_next = S_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SHIFT_RD:
            begin
                if (flags.is_final)
                begin
                    len_wr_en  = 1'b1;
                    len_wr_val = cur_len - LW'(1);
                    res_next   = mk_res(1'b1, '0, 1'b0, '0, 1'b1);
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {list_reg, pos_inc[VW-1:0]};
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                pos_next   = pos_inc;
                state_next = S_SHIFT_RD;
            end

            S_NEXT_LIST:
            begin
                if (more_lists)
                begin
                    list_next  = list_inc[VW-1:0];
                    pos_next   = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    if (pend_valid_reg)
                    begin
                        res_next = mk_res(1'b0, pend_vtx_reg, 1'b0, '0, 1'b1);
                    end
                    else
                    begin
                        res_next = mk_res(1'b0, '0, 1'b1, '0, 1'b1);
                    end
                    pend_valid_next = 1'b0;
                    ret_next        = S_IDLE;
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            list_reg       <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            list_reg       <= list_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            if (len_wr_en)
            begin
                len_reg[list_reg] <= len_wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            kind_reg <= kind;
            src_reg  <= source_vertex;
            tgt_reg  <= target_vertex;
        end
        row_reg      <= row_next;
        pend_vtx_reg <= pend_vtx_next;
        res_reg      <= res_next;
    end

    `DGES_ASSERT(a_len_bound, clk, rst_n, cur_len <= LW'(MAX_VERTICES), "list length over capacity")
    `DGES_ASSERT(a_scan_pos, clk, rst_n, (state_reg == S_SCAN_RD) |-> (pos_reg <= cur_len), "scan position past list end")
    `DGES_ASSERT(a_pend_kind, clk, rst_n, pend_valid_reg |-> (kind_reg == dges_pkg::KIND_IN_LIST), "pending in-list vertex outside in-list request")

endmodule
